// File: hdl/accel_tilt_roll_pitch_unit_assert.svh
// assertion macros shared by the tilt checker
`ifndef ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ATRP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define ATRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/atrp_pkg.sv
package atrp_pkg;

    // defaults of the top level parameters
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int CORDIC_STEPS_DEF    = 16;

    // field widths
    localparam int BYTE_W = 8;
    localparam int AXIS_W = 16;

    // square root datapath
    localparam int SQRT_FRAC = 8;
    localparam int SUM_W     = 32;
    localparam int OP_W      = SUM_W + 2 * SQRT_FRAC;
    localparam int ROOT_W    = OP_W / 2;
    localparam int REM_W     = ROOT_W + 2;

    // cordic datapath
    localparam int NUM_W = AXIS_W + 1;
    localparam int CY_W  = NUM_W + SQRT_FRAC;
    localparam int CX_W  = 28;

    // arctangent table, atan(2^-i) scaled by 2^30
    localparam int TABLE_LEN = 24;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ATAN_Q30 [TABLE_LEN] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
        64'sd16383,     64'sd8191,      64'sd4095,      64'sd2047,
        64'sd1023,      64'sd511,       64'sd255,       64'sd127
    };

    // round a q30 angle to frac fraction bits
    function automatic longint round_q30(longint v, int frac);
        return (v + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
    endfunction

    // saturation limit of the output angle
    function automatic longint angle_lim(int frac);
        return round_q30(HALF_PI_Q30, frac);
    endfunction

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } accel_t;

endpackage

// File: hdl/atrp_in_if.sv
interface atrp_in_if;
    logic                      valid;
    logic                      ready;
    logic [atrp_pkg::BYTE_W-1:0] x_low;
    logic [atrp_pkg::BYTE_W-1:0] x_high;
    logic [atrp_pkg::BYTE_W-1:0] y_low;
    logic [atrp_pkg::BYTE_W-1:0] y_high;
    logic [atrp_pkg::BYTE_W-1:0] z_low;
    logic [atrp_pkg::BYTE_W-1:0] z_high;

    modport source (output valid, x_low, x_high, y_low, y_high, z_low, z_high,
                    input ready);
    modport sink   (input valid, x_low, x_high, y_low, y_high, z_low, z_high,
                    output ready);
endinterface

// File: hdl/atrp_out_if.sv
interface atrp_out_if #(
    parameter int ANGLE_W = atrp_pkg::ANGLE_FRAC_BITS_DEF + 2
);
    logic                               valid;
    logic                               ready;
    logic signed [atrp_pkg::AXIS_W-1:0] accel_x;
    logic signed [atrp_pkg::AXIS_W-1:0] accel_y;
    logic signed [atrp_pkg::AXIS_W-1:0] accel_z;
    logic signed [ANGLE_W-1:0]          roll_angle;
    logic signed [ANGLE_W-1:0]          pitch_angle;

    modport source (output valid, accel_x, accel_y, accel_z, roll_angle, pitch_angle,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, roll_angle, pitch_angle,
                    output ready);
endinterface

// File: hdl/atrp_sqrt.sv
// pipelined integer square root, one root bit per stage
module atrp_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [atrp_pkg::SUM_W-1:0]   radicand,
    output logic                         out_valid,
    output logic [atrp_pkg::ROOT_W-1:0]  root
);

    localparam int ROOT_W = atrp_pkg::ROOT_W;
    localparam int REM_W  = atrp_pkg::REM_W;
    localparam int OP_W   = atrp_pkg::OP_W;

    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [OP_W-1:0]   op_reg   [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [OP_W-1:0]   op_in;
        logic [ROOT_W-1:0] root_in;
        logic              vld_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        // stage inputs
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign op_in   = {radicand, {(2 * atrp_pkg::SQRT_FRAC){1'b0}}};
            assign root_in = '0;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign op_in   = op_reg[k-1];
            assign root_in = root_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        // one restoring step
        assign rem_sh = {rem_in[REM_W-3:0], op_in[OP_W-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_sh - trial) : rem_sh;
                    op_reg[k]  <= {op_in[OP_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign root      = root_reg[ROOT_W-1];
    assign out_valid = vld_reg[ROOT_W-1];

endmodule

// File: hdl/atrp_cordic.sv
// pipelined vectoring cordic, one rotation per stage, then saturation
module atrp_cordic #(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = atrp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [atrp_pkg::ROOT_W-1:0]        x_in,
    input  logic signed [atrp_pkg::CY_W-1:0]   y_in,
    output logic                               out_valid,
    output logic signed [ANGLE_FRAC_BITS+1:0]  angle
);

    localparam int CX_W   = atrp_pkg::CX_W;
    localparam int AW     = ANGLE_FRAC_BITS + 3;
    localparam int OW     = ANGLE_FRAC_BITS + 2;
    localparam logic signed [AW-1:0] LIM = AW'(atrp_pkg::angle_lim(ANGLE_FRAC_BITS));

    logic signed [CX_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [CX_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [AW-1:0]   a_reg [CORDIC_STEPS];
    logic                   z_reg [CORDIC_STEPS];
    logic                   v_reg [CORDIC_STEPS];

    logic signed [OW-1:0]   angle_reg;
    logic signed [OW-1:0]   angle_next;
    logic                   valid_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [AW-1:0] T_I =
            AW'(atrp_pkg::round_q30(atrp_pkg::ATAN_Q30[i], ANGLE_FRAC_BITS));
        logic signed [CX_W-1:0] xi;
        logic signed [CX_W-1:0] yi;
        logic signed [AW-1:0]   ai;
        logic                   zi;
        logic                   vi;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;

        // stage inputs, both-zero flag taken at entry
        if (i == 0) begin : g_first
            assign xi = $signed({{(CX_W - atrp_pkg::ROOT_W){1'b0}}, x_in});
            assign yi = CX_W'(y_in);
            assign ai = '0;
            assign zi = (x_in == '0) && (y_in == '0);
            assign vi = in_valid;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = a_reg[i-1];
            assign zi = z_reg[i-1];
            assign vi = v_reg[i-1];
        end

        assign xs = xi >>> i;
        assign ys = yi >>> i;

        // rotate toward the x axis
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!yi[CX_W-1])
                begin
                    x_reg[i] <= xi + ys;
                    y_reg[i] <= yi - xs;
                    a_reg[i] <= ai + T_I;
                end
                else
                begin
                    x_reg[i] <= xi - ys;
                    y_reg[i] <= yi + xs;
                    a_reg[i] <= ai - T_I;
                end
                z_reg[i] <= zi;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= vi;
            end
        end
    end

    // saturate, force zero when both arguments were zero
    always_comb
    begin
        if (z_reg[CORDIC_STEPS-1])
        begin
            angle_next = '0;
        end
        else if (a_reg[CORDIC_STEPS-1] > LIM)
        begin
            angle_next = OW'(LIM);
        end
        else if (a_reg[CORDIC_STEPS-1] < -LIM)
        begin
            angle_next = OW'(-LIM);
        end
        else
        begin
            angle_next = OW'(a_reg[CORDIC_STEPS-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= v_reg[CORDIC_STEPS-1];
        end
    end

    assign angle     = angle_reg;
    assign out_valid = valid_reg;

endmodule

// File: hdl/accel_tilt_roll_pitch_unit.sv
// beat to result: input, square and sum registers, then root, cordic, saturation stages
// throughput: one beat per cycle unless the output stalls; square root and cordic
// are fully pipelined, one root bit and one rotation per stage
// the whole pipeline halts while a result waits at the output and is not taken
// reset clears the valid bits only; data registers keep whatever they hold
module accel_tilt_roll_pitch_unit #(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STEPS    = atrp_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    atrp_in_if.sink     sample,
    atrp_out_if.source  result
);

    localparam int ANGLE_W  = ANGLE_FRAC_BITS + 2;
    localparam int ROOT_W   = atrp_pkg::ROOT_W;
    localparam int SUM_W    = atrp_pkg::SUM_W;
    localparam int AXIS_W   = atrp_pkg::AXIS_W;
    localparam int SIDE_LEN = ROOT_W + CORDIC_STEPS + 1;

    logic en;

    atrp_pkg::accel_t  acc1_reg;
    atrp_pkg::accel_t  acc2_reg;
    atrp_pkg::accel_t  acc3_reg;
    atrp_pkg::accel_t  side_reg [SIDE_LEN];
    logic [SUM_W-1:0]  sqx_reg;
    logic [SUM_W-1:0]  sqy_reg;
    logic [SUM_W-1:0]  sqz_reg;
    logic [SUM_W-1:0]  sum_roll_reg;
    logic [SUM_W-1:0]  sum_pitch_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;

    logic                                 root_roll_valid;
    logic                                 root_pitch_valid;
    logic [ROOT_W-1:0]                    root_roll;
    logic [ROOT_W-1:0]                    root_pitch;
    atrp_pkg::accel_t                     acc_mid;
    logic signed [atrp_pkg::NUM_W-1:0]    num_roll;
    logic signed [atrp_pkg::NUM_W-1:0]    num_pitch;
    logic signed [atrp_pkg::CY_W-1:0]     y_roll;
    logic signed [atrp_pkg::CY_W-1:0]     y_pitch;
    logic                                 roll_valid;
    logic                                 pitch_valid;
    logic signed [ANGLE_W-1:0]            roll;
    logic signed [ANGLE_W-1:0]            pitch;

    // pipeline advances unless a result is held at the output
    assign en           = !roll_valid || result.ready;
    assign sample.ready = en;

    // assemble the axes, square them, add
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc1_reg.x    <= $signed({sample.x_high, sample.x_low});
            acc1_reg.y    <= $signed({sample.y_high, sample.y_low});
            acc1_reg.z    <= $signed({sample.z_high, sample.z_low});
            sqx_reg       <= SUM_W'(acc1_reg.x * acc1_reg.x);
            sqy_reg       <= SUM_W'(acc1_reg.y * acc1_reg.y);
            sqz_reg       <= SUM_W'(acc1_reg.z * acc1_reg.z);
            acc2_reg      <= acc1_reg;
            sum_roll_reg  <= sqx_reg + sqz_reg;
            sum_pitch_reg <= sqy_reg + sqz_reg;
            acc3_reg      <= acc2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= sample.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // axis values ride alongside the root and cordic stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= acc3_reg;
            for (int k = 1; k < SIDE_LEN; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    atrp_sqrt u_sqrt_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (sum_roll_reg),
        .out_valid (root_roll_valid),
        .root      (root_roll)
    );

    atrp_sqrt u_sqrt_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (sum_pitch_reg),
        .out_valid (root_pitch_valid),
        .root      (root_pitch)
    );

    // numerators: y for roll, -x for pitch, scaled to the root's format
    assign acc_mid   = side_reg[ROOT_W-1];
    assign num_roll  = atrp_pkg::NUM_W'(acc_mid.y);
    assign num_pitch = -atrp_pkg::NUM_W'(acc_mid.x);
    assign y_roll    = {num_roll,  {atrp_pkg::SQRT_FRAC{1'b0}}};
    assign y_pitch   = {num_pitch, {atrp_pkg::SQRT_FRAC{1'b0}}};

    atrp_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_cordic_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_roll_valid),
        .x_in      (root_roll),
        .y_in      (y_roll),
        .out_valid (roll_valid),
        .angle     (roll)
    );

    atrp_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_cordic_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_pitch_valid && root_roll_valid),
        .x_in      (root_pitch),
        .y_in      (y_pitch),
        .out_valid (pitch_valid),
        .angle     (pitch)
    );

    // result beat
    assign result.valid       = roll_valid && pitch_valid;
    assign result.accel_x     = AXIS_W'(side_reg[SIDE_LEN-1].x);
    assign result.accel_y     = AXIS_W'(side_reg[SIDE_LEN-1].y);
    assign result.accel_z     = AXIS_W'(side_reg[SIDE_LEN-1].z);
    assign result.roll_angle  = roll;
    assign result.pitch_angle = pitch;

endmodule

// File: hdl/atrp_checker.sv
`include "accel_tilt_roll_pitch_unit_assert.svh"

// port-level checks of the tilt unit
module atrp_checker #(
    parameter int ANGLE_FRAC_BITS = atrp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [atrp_pkg::AXIS_W-1:0] accel_x,
    input logic signed [atrp_pkg::AXIS_W-1:0] accel_y,
    input logic signed [atrp_pkg::AXIS_W-1:0] accel_z,
    input logic signed [ANGLE_FRAC_BITS+1:0]  roll_angle,
    input logic signed [ANGLE_FRAC_BITS+1:0]  pitch_angle
);

    localparam int ANGLE_W = ANGLE_FRAC_BITS + 2;
    localparam logic signed [ANGLE_W-1:0] LIM =
        ANGLE_W'(atrp_pkg::angle_lim(ANGLE_FRAC_BITS));

    // a held result beat stays valid and keeps its roll angle
    `ATRP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(roll_angle), "result beat changed while stalled")

    // with no result waiting the input side is open
    `ATRP_ASSERT_NOW(a_open, !out_valid, in_ready, "input blocked with empty output")

    // angles stay within plus or minus half pi
    `ATRP_ASSERT_NOW(a_range, out_valid, roll_angle <= LIM && roll_angle >= -LIM && pitch_angle <= LIM && pitch_angle >= -LIM, "angle out of range")

    // all-zero sample gives zero angles
    `ATRP_ASSERT_NOW(a_zero, out_valid && accel_x == '0 && accel_y == '0 && accel_z == '0, roll_angle == '0 && pitch_angle == '0, "nonzero angle for zero sample")

endmodule

bind accel_tilt_roll_pitch_unit atrp_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_atrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (sample.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .accel_x     (result.accel_x),
    .accel_y     (result.accel_y),
    .accel_z     (result.accel_z),
    .roll_angle  (result.roll_angle),
    .pitch_angle (result.pitch_angle)
);
